@@ hw/rtl/camera_path_window_smoother_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the camera path window smoother
// Concurrent check helpers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef CAMERA_PATH_WINDOW_SMOOTHER_TOP_DEFINES_SVH
`define CAMERA_PATH_WINDOW_SMOOTHER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define CPWS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpws check failed");
// Next-cycle implication, disabled during reset.
`define CPWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpws check failed");
`else
`define CPWS_ASSERT_NOW(label, clk, rst, ante, cons)
`define CPWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/cpws_pkg.sv @@
// ----------------------------------------------------------------------------
// Camera path window smoother package
// Shared widths, register codes, state type, ring entry layout and helpers.
// ----------------------------------------------------------------------------
package cpws_pkg;

  localparam int SHIFT_W    = 24;
  localparam int TURN_W     = 16;
  localparam int FACE_W     = 20;
  localparam int POS_W      = 32;
  localparam int PTURN_W    = 24;
  localparam int FIX_W      = 32;
  localparam int FIXT_W     = 24;
  localparam int IDX_W      = 16;
  localparam int RAD_W      = 5;
  localparam int WGT_W      = 9;
  localparam int CTR_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int SUM_W      = 38;
  localparam int TSUM_W     = 30;
  localparam int QSUM_W     = 26;
  localparam int CNT_W      = 6;
  localparam int OUTN_W     = 6;
  localparam int MAX_OUT    = 32;
  localparam int DIV_CNT_W  = 6;

  localparam logic [WGT_W-1:0] FACE_MIN_WEIGHT = 9'd2;
  localparam logic [WGT_W-1:0] FULL_WEIGHT     = 9'd256;

  localparam logic [RAD_W-1:0] PATH_RADIUS_RST = 5'd20;
  localparam logic [RAD_W-1:0] FACE_RADIUS_RST = 5'd5;
  localparam logic [WGT_W-1:0] FACE_WEIGHT_RST = 9'd0;
  localparam logic [CTR_W-1:0] CENTER_X_RST    = 20'd81920;
  localparam logic [CTR_W-1:0] CENTER_Y_RST    = 20'd61440;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATH_RADIUS = 3'd0,
    CFG_FACE_RADIUS = 3'd1,
    CFG_FACE_WEIGHT = 3'd2,
    CFG_CENTER_X    = 3'd3,
    CFG_CENTER_Y    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN,
    ST_DIV,
    ST_BLEND,
    ST_FORM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic signed [TURN_W-1:0]  turn;
    logic signed [POS_W-1:0]   path_x;
    logic signed [POS_W-1:0]   path_y;
    logic signed [PTURN_W-1:0] path_turn;
    logic [FACE_W-1:0]         face_x;
    logic [FACE_W-1:0]         face_y;
  } ring_entry_t;

  function automatic logic signed [POS_W-1:0] sat_to32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = 38'sd2147483647;
    lo = -38'sd2147483648;
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [PTURN_W-1:0] sat_to24(input logic signed [25:0] v);
    logic signed [25:0] hi;
    logic signed [25:0] lo;
    hi = 26'sd8388607;
    lo = -26'sd8388608;
    if (v > hi) begin
      return 24'sh7fffff;
    end else if (v < lo) begin
      return 24'sh800000;
    end
    return v[PTURN_W-1:0];
  endfunction

endpackage

@@ hw/rtl/cpws_in_if.sv @@
// ----------------------------------------------------------------------------
// Camera path window smoother input channel
// Valid/ready channel carrying one frame motion request.
// ----------------------------------------------------------------------------
interface cpws_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cpws_pkg::SHIFT_W-1:0]   shift_x;
  logic signed [cpws_pkg::SHIFT_W-1:0]   shift_y;
  logic signed [cpws_pkg::TURN_W-1:0]    turn;
  logic [cpws_pkg::FACE_W-1:0]           face_x;
  logic [cpws_pkg::FACE_W-1:0]           face_y;
  logic                                  stream_last;

  modport source (output valid, shift_x, shift_y, turn, face_x, face_y, stream_last,
                  input ready);
  modport sink (input valid, shift_x, shift_y, turn, face_x, face_y, stream_last,
                output ready);
endinterface

@@ hw/rtl/cpws_out_if.sv @@
// ----------------------------------------------------------------------------
// Camera path window smoother output channel
// Valid/ready channel carrying one corrected motion request.
// ----------------------------------------------------------------------------
interface cpws_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cpws_pkg::FIX_W-1:0]     fixed_x;
  logic signed [cpws_pkg::FIX_W-1:0]     fixed_y;
  logic signed [cpws_pkg::FIXT_W-1:0]    fixed_turn;
  logic [cpws_pkg::IDX_W-1:0]            frame_index;
  logic                                  run_end;

  modport source (output valid, fixed_x, fixed_y, fixed_turn, frame_index, run_end,
                  input ready);
  modport sink (input valid, fixed_x, fixed_y, fixed_turn, frame_index, run_end,
                output ready);
endinterface

@@ hw/rtl/camera_path_window_smoother_top.sv @@
// ----------------------------------------------------------------------------
// Camera path window smoother
// Accumulates frame motion into a camera path and emits smoothed motion.
// ----------------------------------------------------------------------------
// Each input request carries one frame-to-frame motion and the mean face
// position; the block adds the motion into a saturating camera path, keeps the
// history in a ring memory, and emits one corrected motion per frame once R
// newer frames have arrived, where R is the larger of the two clamped radii.
// A request with stream_last set flushes every pending frame (at most 32) and
// then restarts the stream. The block takes one request at a time: ready is
// high only while it is idle. Each result walks the window through the ring's
// single read port, then runs 3 divisions (7 in face mode) on the one shared
// bit-serial divider, uses the shared multiplier for the blend in face mode,
// and finally forms and presents the result. Configuration is written
// through cfg_we, cfg_index and cfg_data while idle.
// ----------------------------------------------------------------------------
`include "camera_path_window_smoother_top_defines.svh"

module camera_path_window_smoother_top #(
  parameter int MAX_RADIUS = 31,
  parameter int RING_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  cpws_in_if.sink                             in_ch,
  cpws_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [cpws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpws_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW      = $clog2(RING_DEPTH);
  localparam int HALF_RD = (RING_DEPTH - 2) / 2;
  localparam int LIM_R   = (MAX_RADIUS < HALF_RD) ? MAX_RADIUS : HALF_RD;
  localparam logic [cpws_pkg::RAD_W-1:0] LIM = cpws_pkg::RAD_W'(LIM_R);

  // Configuration registers.
  logic [cpws_pkg::RAD_W-1:0] path_radius;
  logic [cpws_pkg::RAD_W-1:0] face_radius;
  logic [cpws_pkg::WGT_W-1:0] face_weight;
  logic [cpws_pkg::CTR_W-1:0] center_x;
  logic [cpws_pkg::CTR_W-1:0] center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_radius <= cpws_pkg::PATH_RADIUS_RST;
      face_radius <= cpws_pkg::FACE_RADIUS_RST;
      face_weight <= cpws_pkg::FACE_WEIGHT_RST;
      center_x    <= cpws_pkg::CENTER_X_RST;
      center_y    <= cpws_pkg::CENTER_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cpws_pkg::CFG_PATH_RADIUS: path_radius <= cfg_data[cpws_pkg::RAD_W-1:0];
        cpws_pkg::CFG_FACE_RADIUS: face_radius <= cfg_data[cpws_pkg::RAD_W-1:0];
        cpws_pkg::CFG_FACE_WEIGHT: face_weight <= cfg_data[cpws_pkg::WGT_W-1:0];
        cpws_pkg::CFG_CENTER_X:    center_x    <= cfg_data;
        cpws_pkg::CFG_CENTER_Y:    center_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped radii, the emission lag R, face mode and the effective weight.
  logic [cpws_pkg::RAD_W-1:0] rp;
  logic [cpws_pkg::RAD_W-1:0] rf;
  logic [cpws_pkg::RAD_W-1:0] rmax;
  logic                       face_on;
  logic [cpws_pkg::WGT_W-1:0] w_eff;

  assign rp      = (path_radius > LIM) ? LIM : path_radius;
  assign rf      = (face_radius > LIM) ? LIM : face_radius;
  assign rmax    = (rp > rf) ? rp : rf;
  assign face_on = face_weight > cpws_pkg::FACE_MIN_WEIGHT;
  assign w_eff   = (face_weight > cpws_pkg::FULL_WEIGHT) ? cpws_pkg::FULL_WEIGHT : face_weight;

  // Sequencer state and stream bookkeeping.
  cpws_pkg::state_t state;
  cpws_pkg::state_t state_next;

  logic [cpws_pkg::IDX_W-1:0]        frames_seen;
  logic [cpws_pkg::IDX_W-1:0]        next_emit;
  logic                              long_run;
  logic                              last_flag;
  logic signed [cpws_pkg::POS_W-1:0]   path_sum_x;
  logic signed [cpws_pkg::POS_W-1:0]   path_sum_y;
  logic signed [cpws_pkg::PTURN_W-1:0] path_sum_turn;
  logic [cpws_pkg::IDX_W-1:0]        pending;
  logic [cpws_pkg::OUTN_W-1:0]       n_out;
  logic [cpws_pkg::CNT_W-1:0]        k;
  logic [2:0]                        div_sel;
  logic                              div_wait;
  logic [2:0]                        bstep;

  logic accept_in;
  logic accept_out;
  assign accept_in  = in_ch.valid && in_ch.ready;
  assign accept_out = out_ch.valid && out_ch.ready;

  // A frame is released when it has R newer frames, or on a flush.
  logic [cpws_pkg::IDX_W-1:0] avail;
  logic                       emit_ok;
  logic [cpws_pkg::IDX_W-1:0] pend_after;
  logic                       more;

  assign avail      = frames_seen - next_emit;
  assign emit_ok    = (avail != '0) && (last_flag || avail > cpws_pkg::IDX_W'(rmax))
                      && (n_out < cpws_pkg::OUTN_W'(cpws_pkg::MAX_OUT));
  assign pend_after = pending - 1'b1;
  assign more       = (pend_after != '0) && (last_flag || pend_after > cpws_pkg::IDX_W'(rmax))
                      && ((n_out + 1'b1) < cpws_pkg::OUTN_W'(cpws_pkg::MAX_OUT));

  // New path sums on an accepted frame; they saturate at every add.
  logic signed [cpws_pkg::POS_W-1:0]   new_sum_x;
  logic signed [cpws_pkg::POS_W-1:0]   new_sum_y;
  logic signed [cpws_pkg::PTURN_W-1:0] new_sum_t;

  assign new_sum_x = cpws_pkg::sat_to32(cpws_pkg::SUM_W'(path_sum_x) + cpws_pkg::SUM_W'(in_ch.shift_x));
  assign new_sum_y = cpws_pkg::sat_to32(cpws_pkg::SUM_W'(path_sum_y) + cpws_pkg::SUM_W'(in_ch.shift_y));
  assign new_sum_t = cpws_pkg::sat_to24(26'(path_sum_turn) + 26'(in_ch.turn));

  // Window walk: offset j runs from -R to +R, one ring read per cycle.
  logic signed [6:0]          j;
  logic [cpws_pkg::RAD_W-1:0] j_abs;
  logic                       j_neg;
  logic                       in_win;
  logic                       use_p;
  logic                       use_f;
  logic [AW-1:0]              raddr;
  logic [cpws_pkg::IDX_W-1:0] slot_full;

  assign j      = $signed({1'b0, k}) - $signed({2'b00, rmax});
  assign j_neg  = j[6];
  assign j_abs  = j_neg ? cpws_pkg::RAD_W'(-j) : j[cpws_pkg::RAD_W-1:0];
  assign in_win = j_neg ? (long_run || next_emit >= cpws_pkg::IDX_W'(j_abs))
                        : (cpws_pkg::IDX_W'(j_abs) < pending);
  assign use_p  = in_win && (j_abs <= rp);
  assign use_f  = in_win && (j_abs <= rf);
  assign slot_full = next_emit + cpws_pkg::IDX_W'(j);
  assign raddr  = slot_full[AW-1:0];

  cpws_pkg::ring_entry_t wentry;
  cpws_pkg::ring_entry_t rentry;

  always_comb begin
    wentry.shift_x   = in_ch.shift_x;
    wentry.shift_y   = in_ch.shift_y;
    wentry.turn      = in_ch.turn;
    wentry.path_x    = new_sum_x;
    wentry.path_y    = new_sum_y;
    wentry.path_turn = new_sum_t;
    wentry.face_x    = in_ch.face_x;
    wentry.face_y    = in_ch.face_y;
  end

  cpws_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (accept_in),
    .waddr (frames_seen[AW-1:0]),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rentry)
  );

  // Window accumulators; the take flags are registered alongside the ring read data.
  logic take_p;
  logic take_f;
  logic take0;
  logic signed [cpws_pkg::SUM_W-1:0]  sx;
  logic signed [cpws_pkg::SUM_W-1:0]  sy;
  logic signed [cpws_pkg::TSUM_W-1:0] st;
  logic signed [cpws_pkg::SUM_W-1:0]  px;
  logic signed [cpws_pkg::SUM_W-1:0]  py;
  logic [cpws_pkg::QSUM_W-1:0]        qx;
  logic [cpws_pkg::QSUM_W-1:0]        qy;
  logic [cpws_pkg::CNT_W-1:0]         cnt_p;
  logic [cpws_pkg::CNT_W-1:0]         cnt_f;
  logic signed [cpws_pkg::SHIFT_W-1:0] mv_x;
  logic signed [cpws_pkg::SHIFT_W-1:0] mv_y;
  logic signed [cpws_pkg::TURN_W-1:0]  mv_t;
  logic signed [cpws_pkg::POS_W-1:0]   p0_x;
  logic signed [cpws_pkg::POS_W-1:0]   p0_y;
  logic signed [cpws_pkg::PTURN_W-1:0] p0_t;

  // Shared divider and its operand selection.
  logic                               div_start;
  logic                               div_done;
  logic signed [cpws_pkg::SUM_W-1:0]  div_num;
  logic [cpws_pkg::CNT_W-1:0]         div_den;
  logic signed [cpws_pkg::SUM_W-1:0]  div_quo;
  logic [2:0]                         div_last;

  assign div_start = (state == cpws_pkg::ST_DIV) && !div_wait;
  assign div_last  = face_on ? 3'd6 : 3'd2;

  always_comb begin
    div_den = cnt_p;
    case (div_sel)
      3'd0: div_num = sx;
      3'd1: div_num = sy;
      3'd2: div_num = cpws_pkg::SUM_W'(st);
      3'd3: begin div_num = px; div_den = cnt_f; end
      3'd4: begin div_num = py; div_den = cnt_f; end
      3'd5: begin div_num = $signed({12'b0, qx}); div_den = cnt_f; end
      3'd6: begin div_num = $signed({12'b0, qy}); div_den = cnt_f; end
      default: div_num = sx;
    endcase
  end

  cpws_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic signed [cpws_pkg::POS_W-1:0]   avg_x;
  logic signed [cpws_pkg::POS_W-1:0]   avg_y;
  logic signed [cpws_pkg::PTURN_W-1:0] avg_t;
  logic signed [cpws_pkg::POS_W-1:0]   fpx;
  logic signed [cpws_pkg::POS_W-1:0]   fpy;
  logic [cpws_pkg::FACE_W-1:0]         fqx;
  logic [cpws_pkg::FACE_W-1:0]         fqy;

  // Face blend on one shared multiplier:
  // (avg*(256-w) + (face path avg - face avg + center)*w) / 256, toward zero.
  logic signed [33:0] pdx;
  logic signed [33:0] pdy;
  logic signed [33:0] mul_a;
  logic signed [9:0]  mul_b;
  logic signed [43:0] prod;
  logic signed [43:0] acc;
  logic signed [44:0] bsum;
  logic signed [35:0] bdiv;
  logic signed [35:0] bx;
  logic signed [35:0] by;

  assign pdx = 34'(fpx) - $signed({14'b0, fqx}) + $signed({14'b0, center_x});
  assign pdy = 34'(fpy) - $signed({14'b0, fqy}) + $signed({14'b0, center_y});

  always_comb begin
    case (bstep)
      3'd0: begin mul_a = 34'(avg_x); mul_b = $signed(10'(cpws_pkg::FULL_WEIGHT - w_eff)); end
      3'd1: begin mul_a = pdx;        mul_b = $signed({1'b0, w_eff}); end
      3'd2: begin mul_a = 34'(avg_y); mul_b = $signed(10'(cpws_pkg::FULL_WEIGHT - w_eff)); end
      3'd3: begin mul_a = pdy;        mul_b = $signed({1'b0, w_eff}); end
      default: begin mul_a = pdy;     mul_b = $signed({1'b0, w_eff}); end
    endcase
  end

  assign bsum = 45'(acc) + 45'(prod);
  assign bdiv = 36'((bsum + (bsum[44] ? 45'sd255 : 45'sd0)) >>> 8);

  // Final correction: motion + (smoothed path - raw path), saturated.
  logic signed [35:0]                  sel_x;
  logic signed [35:0]                  sel_y;
  logic signed [cpws_pkg::FIX_W-1:0]   res_x;
  logic signed [cpws_pkg::FIX_W-1:0]   res_y;
  logic signed [cpws_pkg::FIXT_W-1:0]  res_t;

  assign sel_x = face_on ? bx : 36'(avg_x);
  assign sel_y = face_on ? by : 36'(avg_y);
  assign res_x = cpws_pkg::sat_to32(cpws_pkg::SUM_W'(mv_x) + cpws_pkg::SUM_W'(sel_x)
                                    - cpws_pkg::SUM_W'(p0_x));
  assign res_y = cpws_pkg::sat_to32(cpws_pkg::SUM_W'(mv_y) + cpws_pkg::SUM_W'(sel_y)
                                    - cpws_pkg::SUM_W'(p0_y));
  assign res_t = cpws_pkg::sat_to24(26'(mv_t) + 26'(avg_t) - 26'(p0_t));

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      cpws_pkg::ST_IDLE:  if (accept_in) state_next = cpws_pkg::ST_CHECK;
      cpws_pkg::ST_CHECK: state_next = emit_ok ? cpws_pkg::ST_WALK : cpws_pkg::ST_IDLE;
      cpws_pkg::ST_WALK:  if (k == cpws_pkg::CNT_W'({rmax, 1'b0})) state_next = cpws_pkg::ST_DRAIN;
      cpws_pkg::ST_DRAIN: state_next = cpws_pkg::ST_DIV;
      cpws_pkg::ST_DIV: begin
        if (div_done && div_sel == div_last) begin
          state_next = face_on ? cpws_pkg::ST_BLEND : cpws_pkg::ST_FORM;
        end
      end
      cpws_pkg::ST_BLEND: if (bstep == 3'd4) state_next = cpws_pkg::ST_FORM;
      cpws_pkg::ST_FORM:  state_next = cpws_pkg::ST_OUT;
      cpws_pkg::ST_OUT:   if (accept_out) state_next = cpws_pkg::ST_CHECK;
      default:            state_next = cpws_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ch.ready  = (state == cpws_pkg::ST_IDLE);
    out_ch.valid = (state == cpws_pkg::ST_OUT);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cpws_pkg::ST_IDLE;
      frames_seen   <= '0;
      next_emit     <= '0;
      long_run      <= 1'b0;
      path_sum_x    <= '0;
      path_sum_y    <= '0;
      path_sum_turn <= '0;
      last_flag     <= 1'b0;
      n_out         <= '0;
      k             <= '0;
      div_sel       <= '0;
      div_wait      <= 1'b0;
      bstep         <= '0;
      take_p        <= 1'b0;
      take_f        <= 1'b0;
      take0         <= 1'b0;
    end else begin
      state  <= state_next;
      take_p <= 1'b0;
      take_f <= 1'b0;
      take0  <= 1'b0;
      case (state)
        cpws_pkg::ST_IDLE: begin
          if (accept_in) begin
            path_sum_x    <= new_sum_x;
            path_sum_y    <= new_sum_y;
            path_sum_turn <= new_sum_t;
            frames_seen   <= frames_seen + 1'b1;
            if (frames_seen == '1) begin
              long_run <= 1'b1;
            end
            last_flag <= in_ch.stream_last;
            n_out     <= '0;
          end
        end
        cpws_pkg::ST_CHECK: begin
          k <= '0;
          if (!emit_ok && last_flag) begin
            // Flush done: the next request starts a fresh stream.
            frames_seen   <= '0;
            next_emit     <= '0;
            long_run      <= 1'b0;
            path_sum_x    <= '0;
            path_sum_y    <= '0;
            path_sum_turn <= '0;
          end
        end
        cpws_pkg::ST_WALK: begin
          k      <= k + 1'b1;
          take_p <= use_p;
          take_f <= use_f;
          take0  <= (j == 7'sd0);
          div_sel  <= '0;
          div_wait <= 1'b0;
        end
        cpws_pkg::ST_DIV: begin
          if (div_start) begin
            div_wait <= 1'b1;
          end else if (div_done) begin
            div_wait <= 1'b0;
            div_sel  <= div_sel + 1'b1;
          end
          bstep <= '0;
        end
        cpws_pkg::ST_BLEND: bstep <= bstep + 1'b1;
        cpws_pkg::ST_OUT: begin
          if (accept_out) begin
            next_emit <= next_emit + 1'b1;
            n_out     <= n_out + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == cpws_pkg::ST_CHECK) begin
      pending <= avail;
      sx <= '0; sy <= '0; st <= '0; px <= '0; py <= '0; qx <= '0; qy <= '0;
      cnt_p <= '0;
      cnt_f <= '0;
    end else begin
      if (take_p) begin
        sx    <= sx + cpws_pkg::SUM_W'(rentry.path_x);
        sy    <= sy + cpws_pkg::SUM_W'(rentry.path_y);
        st    <= st + cpws_pkg::TSUM_W'(rentry.path_turn);
        cnt_p <= cnt_p + 1'b1;
      end
      if (take_f) begin
        px    <= px + cpws_pkg::SUM_W'(rentry.path_x);
        py    <= py + cpws_pkg::SUM_W'(rentry.path_y);
        qx    <= qx + cpws_pkg::QSUM_W'(rentry.face_x);
        qy    <= qy + cpws_pkg::QSUM_W'(rentry.face_y);
        cnt_f <= cnt_f + 1'b1;
      end
    end
    if (take0) begin
      mv_x <= rentry.shift_x;
      mv_y <= rentry.shift_y;
      mv_t <= rentry.turn;
      p0_x <= rentry.path_x;
      p0_y <= rentry.path_y;
      p0_t <= rentry.path_turn;
    end
    if (state == cpws_pkg::ST_DIV && div_done) begin
      case (div_sel)
        3'd0: avg_x <= div_quo[cpws_pkg::POS_W-1:0];
        3'd1: avg_y <= div_quo[cpws_pkg::POS_W-1:0];
        3'd2: avg_t <= div_quo[cpws_pkg::PTURN_W-1:0];
        3'd3: fpx   <= div_quo[cpws_pkg::POS_W-1:0];
        3'd4: fpy   <= div_quo[cpws_pkg::POS_W-1:0];
        3'd5: fqx   <= div_quo[cpws_pkg::FACE_W-1:0];
        3'd6: fqy   <= div_quo[cpws_pkg::FACE_W-1:0];
        default: ;
      endcase
    end
    if (state == cpws_pkg::ST_BLEND) begin
      prod <= mul_a * mul_b;
      case (bstep)
        3'd1: acc <= prod;
        3'd2: bx  <= bdiv;
        3'd3: acc <= prod;
        3'd4: by  <= bdiv;
        default: ;
      endcase
    end
    if (state == cpws_pkg::ST_FORM) begin
      out_ch.fixed_x     <= res_x;
      out_ch.fixed_y     <= res_y;
      out_ch.fixed_turn  <= res_t;
      out_ch.frame_index <= next_emit;
      out_ch.run_end     <= !more;
    end
  end

  // The block never takes a new request while a result is still on offer.
  `CPWS_ASSERT_NOW(a_no_overlap, clk, rst, in_ch.ready, !out_ch.valid)
  // Every delivered result advances the emission counter by one frame.
  `CPWS_ASSERT_NEXT(a_emit_step, clk, rst, accept_out,
                    next_emit == cpws_pkg::IDX_W'($past(next_emit) + 1'b1))
  // One request never releases more results than the flush limit.
  `CPWS_ASSERT_NOW(a_out_limit, clk, rst, 1'b1,
                   n_out <= cpws_pkg::OUTN_W'(cpws_pkg::MAX_OUT))
  // A result is only formed from a window that held its own frame.
  `CPWS_ASSERT_NOW(a_count_nonzero, clk, rst, div_start, div_den != '0)

endmodule

@@ hw/rtl/cpws_ring.sv @@
// ----------------------------------------------------------------------------
// Camera path window smoother history ring
// One write port, one registered read port over the per-frame history.
// ----------------------------------------------------------------------------
module cpws_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  cpws_pkg::ring_entry_t wdata,
  input  logic [AW-1:0]         raddr,
  output cpws_pkg::ring_entry_t rdata
);

  cpws_pkg::ring_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/cpws_div.sv @@
// ----------------------------------------------------------------------------
// Camera path window smoother divider
// Signed by unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpws_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [cpws_pkg::SUM_W-1:0]    num,
  input  logic [cpws_pkg::CNT_W-1:0]           den,
  output logic                                 done,
  output logic signed [cpws_pkg::SUM_W-1:0]    quo
);

  logic                               busy;
  logic [cpws_pkg::DIV_CNT_W-1:0]     cnt;
  logic [cpws_pkg::SUM_W-1:0]         mag;
  logic [cpws_pkg::CNT_W-1:0]         rem;
  logic [cpws_pkg::CNT_W-1:0]         den_r;
  logic                               neg;
  logic [cpws_pkg::CNT_W:0]           trial;
  logic                               fits;

  assign trial = {rem, mag[cpws_pkg::SUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= cpws_pkg::DIV_CNT_W'(cpws_pkg::SUM_W - 1);
      mag   <= num[cpws_pkg::SUM_W-1] ? cpws_pkg::SUM_W'(-num) : num;
      neg   <= num[cpws_pkg::SUM_W-1];
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      mag <= {mag[cpws_pkg::SUM_W-2:0], fits};
      rem <= fits ? cpws_pkg::CNT_W'(trial - {1'b0, den_r}) : trial[cpws_pkg::CNT_W-1:0];
    end
  end

  assign quo = neg ? -$signed(mag) : $signed(mag);

endmodule

@@ tb/cpws_checker.sv @@
// ----------------------------------------------------------------------------
// Camera path window smoother checker
// Watches both channels and the register port, predicts every result and
// compares each one as it leaves the block.
// ----------------------------------------------------------------------------
module cpws_checker (
  input  logic                           clk,
  input  logic                           rst,
  cpws_in_if                             in_ch,
  cpws_out_if                            out_ch,
  input  logic                           cfg_we,
  input  logic [cpws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpws_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import cpws_pkg::*;

  localparam int DEPTH = 64;
  localparam int RAD_LIMIT = 31;

  typedef struct {
    logic signed [FIX_W-1:0]  fx;
    logic signed [FIX_W-1:0]  fy;
    logic signed [FIXT_W-1:0] ft;
    logic [IDX_W-1:0]         idx;
    logic                     last;
  } corrected_t;

  corrected_t corrected_q[$];

  logic signed [SHIFT_W-1:0] hist_sx[DEPTH];
  logic signed [SHIFT_W-1:0] hist_sy[DEPTH];
  logic signed [TURN_W-1:0]  hist_turn[DEPTH];
  longint hist_px[DEPTH], hist_py[DEPTH], hist_pt[DEPTH];
  longint hist_fx[DEPTH], hist_fy[DEPTH];
  longint run_x, run_y, run_t;
  int     frames_in, emit_ptr;
  bit     wrapped;
  int     rad_path, rad_face, weight, ctr_x, ctr_y;

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) <<< (w - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic int lim_rad(int r);
    return r > RAD_LIMIT ? RAD_LIMIT : r;
  endfunction

  function automatic int slot(int i, int j);
    return ((i + 65536 + j) & 16'hFFFF) % DEPTH;
  endfunction

  function automatic bit covered(int i, int j, int pend);
    if (j < 0 && !wrapped && i < -j) return 0;
    if (j >= 0 && j >= pend) return 0;
    return 1;
  endfunction

  // Smoothed correction of frame i with pend frames received at or after it.
  function automatic corrected_t smooth_frame(int i, int pend);
    corrected_t r;
    longint sx, sy, st, cnt, ax, ay, at, w, px, py, qx, qy, c, ox, oy;
    int rp, rf, s0, s;
    rp = lim_rad(rad_path);
    rf = lim_rad(rad_face);
    s0 = slot(i, 0);
    sx = 0; sy = 0; st = 0; cnt = 0;
    for (int j = -rp; j <= rp; j++) begin
      if (covered(i, j, pend)) begin
        s = slot(i, j);
        sx += hist_px[s]; sy += hist_py[s]; st += hist_pt[s]; cnt++;
      end
    end
    ax = sx / cnt; ay = sy / cnt; at = st / cnt;
    if (weight > FACE_MIN_WEIGHT) begin
      w = weight > 256 ? 256 : weight;
      px = 0; py = 0; qx = 0; qy = 0; c = 0;
      for (int j = -rf; j <= rf; j++) begin
        if (covered(i, j, pend)) begin
          s = slot(i, j);
          px += hist_px[s]; py += hist_py[s];
          qx += hist_fx[s]; qy += hist_fy[s]; c++;
        end
      end
      ox = qx / c - ctr_x;
      oy = qy / c - ctr_y;
      ax = (ax * (256 - w) + (px / c - ox) * w) / 256;
      ay = (ay * (256 - w) + (py / c - oy) * w) / 256;
    end
    r.fx   = clip(longint'(hist_sx[s0]) + ax - hist_px[s0], 32);
    r.fy   = clip(longint'(hist_sy[s0]) + ay - hist_py[s0], 32);
    r.ft   = clip(longint'(hist_turn[s0]) + at - hist_pt[s0], 24);
    r.idx  = i[15:0];
    r.last = 0;
    return r;
  endfunction

  task automatic take_frame();
    corrected_t batch[MAX_OUT];
    int s, r, n, pend;
    s = frames_in % DEPTH;
    r = lim_rad(rad_path) > lim_rad(rad_face) ? lim_rad(rad_path) : lim_rad(rad_face);
    run_x = clip(run_x + longint'(in_ch.shift_x), 32);
    run_y = clip(run_y + longint'(in_ch.shift_y), 32);
    run_t = clip(run_t + longint'(in_ch.turn), 24);
    hist_sx[s] = in_ch.shift_x;
    hist_sy[s] = in_ch.shift_y;
    hist_turn[s] = in_ch.turn;
    hist_fx[s] = in_ch.face_x;
    hist_fy[s] = in_ch.face_y;
    hist_px[s] = run_x; hist_py[s] = run_y; hist_pt[s] = run_t;
    frames_in = (frames_in + 1) & 16'hFFFF;
    if (frames_in == 0) wrapped = 1;
    n = 0;
    while (n < MAX_OUT) begin
      pend = (frames_in - emit_ptr) & 16'hFFFF;
      if (pend == 0 || (!in_ch.stream_last && pend <= r)) break;
      batch[n] = smooth_frame(emit_ptr, pend);
      emit_ptr = (emit_ptr + 1) & 16'hFFFF;
      n++;
    end
    if (n > 0) batch[n-1].last = 1;
    for (int k = 0; k < n; k++) corrected_q = {corrected_q, batch[k]};
    if (in_ch.stream_last) begin
      run_x = 0; run_y = 0; run_t = 0;
      frames_in = 0; emit_ptr = 0; wrapped = 0;
    end
  endtask

  task automatic check_result();
    corrected_t e;
    if (corrected_q.size() == 0) begin
      $display("%0t: result for frame %0d with no expectation", $time, out_ch.frame_index);
      mismatches++;
      return;
    end
    e = corrected_q.pop_front();
    if (out_ch.fixed_x !== e.fx) begin
      $display("%0t: fixed_x expected %0d actual %0d", $time, e.fx, out_ch.fixed_x);
      mismatches++;
    end
    if (out_ch.fixed_y !== e.fy) begin
      $display("%0t: fixed_y expected %0d actual %0d", $time, e.fy, out_ch.fixed_y);
      mismatches++;
    end
    if (out_ch.fixed_turn !== e.ft) begin
      $display("%0t: fixed_turn expected %0d actual %0d", $time, e.ft, out_ch.fixed_turn);
      mismatches++;
    end
    if (out_ch.frame_index !== e.idx) begin
      $display("%0t: frame_index expected %0d actual %0d", $time, e.idx, out_ch.frame_index);
      mismatches++;
    end
    if (out_ch.run_end !== e.last) begin
      $display("%0t: run_end expected %0d actual %0d", $time, e.last, out_ch.run_end);
      mismatches++;
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    if (rst) begin
      corrected_q.delete();
      run_x = 0; run_y = 0; run_t = 0;
      frames_in = 0; emit_ptr = 0; wrapped = 0;
      rad_path = PATH_RADIUS_RST; rad_face = FACE_RADIUS_RST;
      weight = FACE_WEIGHT_RST; ctr_x = CENTER_X_RST; ctr_y = CENTER_Y_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PATH_RADIUS: rad_path = cfg_data[RAD_W-1:0];
          CFG_FACE_RADIUS: rad_face = cfg_data[RAD_W-1:0];
          CFG_FACE_WEIGHT: weight = cfg_data[WGT_W-1:0];
          CFG_CENTER_X:    ctr_x = cfg_data[CTR_W-1:0];
          CFG_CENTER_Y:    ctr_y = cfg_data[CTR_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) take_frame();
    end
    awaiting = corrected_q.size();
  end
endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Camera path window smoother testbench top
// Drives frame requests and register writes with random pacing; the checker
// beside the block predicts and compares every corrected motion.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpws_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int mismatches;
  int awaiting;

  // Pacing controls shared by the two driver processes.
  bit burst = 0;
  int hold_cycles = 0;

  cpws_in_if  in_ch ();
  cpws_out_if out_ch ();

  camera_path_window_smoother_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cpws_checker u_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.shift_x = '0;
    in_ch.shift_y = '0;
    in_ch.turn = '0;
    in_ch.face_x = '0;
    in_ch.face_y = '0;
    in_ch.stream_last = 0;
    out_ch.ready = 0;
  end

  // Timeout: far above the slowest correct run, including every flush.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Result side. Before each result, ready stays low for a random stall,
  // except in burst stretches. A long hold-off, when requested by the
  // stimulus, is counted out here so the sender keeps offering meanwhile.
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready = 0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready = 0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1;
      // Valid only changes at rising edges and ready at falling edges, so what
      // we see at the falling edge is what the next rising edge accepts.
      while (!out_ch.valid) @(negedge clk);
      @(negedge clk);
    end
  end

  // Offers one frame request and returns at the falling edge after it was
  // accepted. Valid stays high so a back-to-back request needs no toggle.
  task automatic send_frame(logic signed [SHIFT_W-1:0] sx, logic signed [SHIFT_W-1:0] sy,
                            logic signed [TURN_W-1:0] tn, logic [FACE_W-1:0] fx,
                            logic [FACE_W-1:0] fy, logic last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.shift_x = sx;
    in_ch.shift_y = sy;
    in_ch.turn = tn;
    in_ch.face_x = fx;
    in_ch.face_y = fy;
    in_ch.stream_last = last;
    in_ch.valid = 1;
    while (!in_ch.ready) @(negedge clk);
    @(negedge clk);
  endtask

  // Waits until every predicted result has come out, then lets the block
  // finish any request that released nothing before registers change.
  task automatic settle();
    in_ch.valid = 0;
    while (awaiting != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_regs(int pr, int fr, int wt, int cx, int cy);
    write_reg(CFG_PATH_RADIUS, pr);
    write_reg(CFG_FACE_RADIUS, fr);
    write_reg(CFG_FACE_WEIGHT, wt);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
  endtask

  // Shift values lean toward the extremes so the path sums saturate often.
  function automatic logic signed [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      1: return $signed(24'($urandom_range(0, 2047))) - 24'sd1024;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [FACE_W-1:0] pick_face();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 20'hfffff : 20'h0;
      default: return 20'($urandom);
    endcase
  endfunction

  // A random stream of len frames, ending with stream_last when closed.
  task automatic random_stream(int len, bit closed);
    for (int k = 0; k < len; k++) begin
      send_frame(pick_shift(), pick_shift(), 16'($urandom), pick_face(), pick_face(),
                 closed && k == len - 1);
    end
  endtask

  initial begin
    int pr, fr, wt, len;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed part with the reset register values: field extremes, a stream
    // of one frame, a stream that ends before any frame is released on its
    // own, and stream_last on consecutive requests.
    send_frame(24'sh7fffff, 24'sh800000, 16'sh7fff, 20'hfffff, 20'h0, 0);
    send_frame(24'sh800000, 24'sh7fffff, 16'sh8000, 20'h0, 20'hfffff, 0);
    send_frame(24'sh0, 24'sh0, 16'sh0, 20'h0, 20'h0, 0);
    send_frame(24'sh7fffff, 24'sh7fffff, 16'sh7fff, 20'hfffff, 20'hfffff, 1);
    send_frame(24'sh000100, -24'sh000100, 16'sh2000, 20'h14000, 20'h0f000, 1);
    send_frame(-24'sh1, 24'sh1, -16'sh1, 20'h1, 20'h1, 1);
    settle();

    // Zero radii: each frame comes out as soon as it arrives, face mode on
    // at full weight with the center at its extremes.
    set_regs(0, 0, 256, 0, 1048575);
    for (int k = 0; k < 6; k++)
      send_frame(k[0] ? 24'sh7fffff : 24'sh800000, 24'($urandom), 16'($urandom),
                 k[1] ? 20'hfffff : 20'h0, pick_face(), k == 5);
    settle();

    // Largest radii and a weight beyond full scale; the stream is long and
    // ends in a full flush.
    set_regs(31, 31, 511, 524288, 524288);
    random_stream(40, 1);
    settle();

    // Weights at the face-mode threshold, and the reset values again.
    set_regs(3, 1, 2, 81920, 61440);
    random_stream(12, 1);
    settle();
    write_reg(CFG_FACE_WEIGHT, 3);
    random_stream(12, 1);
    settle();
    set_regs(20, 5, 0, 81920, 61440);
    random_stream(25, 1);
    settle();

    // Radius shrunk in the middle of a stream: several frames are released
    // by the next request at once.
    set_regs(25, 25, 100, 40000, 30000);
    random_stream(30, 0);
    settle();
    write_reg(CFG_PATH_RADIUS, 2);
    write_reg(CFG_FACE_RADIUS, 1);
    random_stream(5, 1);
    settle();

    // A long run of one-sided shifts drives the path sums into saturation.
    set_regs(4, 2, 0, 0, 0);
    burst = 1;
    for (int k = 0; k < 270; k++)
      send_frame(24'sh7fffff, 24'sh800000, 16'sh7fff, pick_face(), pick_face(), 0);
    burst = 0;
    send_frame(24'sh800000, 24'sh7fffff, 16'sh8000, 20'h0, 20'h0, 1);
    settle();

    // Long receiver hold-off while requests keep coming, then a sender pause
    // until every result has drained.
    set_regs(1, 0, 0, 0, 0);
    hold_cycles = 600;
    random_stream(20, 0);
    in_ch.valid = 0;
    while (awaiting != 0) @(negedge clk);
    random_stream(5, 1);
    settle();

    // Random phases with random settings and random stream lengths, with
    // occasional burst stretches.
    repeat (2) begin
      pr = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 6);
      fr = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 6);
      wt = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 511);
      set_regs(pr, fr, wt, $urandom_range(0, 1048575), $urandom_range(0, 1048575));
      burst = $urandom_range(0, 3) == 0;
      repeat (3) begin
        len = $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 14);
        random_stream(len, 1);
      end
      burst = 0;
      settle();
    end

    settle();
    repeat (50) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
